// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. They sample on clk_i and are
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PRD_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define PRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/prd_pkg.sv -----
package prd_pkg;

  // Request kinds.
  localparam logic [1:0] REQ_STORE = 2'd0;
  localparam logic [1:0] REQ_MAP   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // Distance kinds.
  localparam logic [1:0] MODE_EUCLID    = 2'd0;
  localparam logic [1:0] MODE_MANHATTAN = 2'd1;
  localparam logic [1:0] MODE_COSINE    = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_DIST_MODE     = 1'b0;
  localparam logic CFG_FEATURE_COUNT = 1'b1;

  localparam logic [63:0] ONE_Q16 = 64'd65536;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         sample_row;
    logic [5:0]         feature_slot;
    logic signed [23:0] sample_value;
    logic [5:0]         map_target;
    logic [5:0]         pair_first;
    logic [5:0]         pair_second;
  } req_item_t;

  typedef struct packed {
    logic [47:0] distance;
    logic        saturated;
  } res_item_t;

endpackage

// ----- rtl/prd_stream_if.sv -----
interface prd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/pairwise_row_distance.sv -----
// Pairwise row distance engine.
// req_if carries requests: a store load writes one Q12.12 value at (row, slot),
// a map load writes one row map entry, and a pair query maps two rows through
// the row map and returns one result on res_if. Loads return nothing.
// Configuration (distance kind, feature count) is written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must write it only while the engine is
// idle, which the block itself does not enforce. A query walks the two rows
// out of the value store at one feature pair per cycle over its two read
// ports, after two row map reads. Manhattan then finishes directly. Euclidean
// adds one bit-serial square root. Cosine runs that root twice, one 32x32
// multiply and a 17-step divider, and skips the multiply and divider when a
// norm is zero. One query is processed at a time, and the next request is
// taken the cycle after its result is loaded. The result waits in an output
// register, so a new request is taken while the receiver stalls; a second
// result waits in the engine until the output register is free. Reset clears
// control state and configuration (Euclidean, 64 features); the stores are
// undefined until loaded, with no clearing pass.
`include "assert_macros.svh"

module pairwise_row_distance
  import prd_pkg::*;
#(
  parameter int MAX_SAMPLES  = 64,
  parameter int MAX_FEATURES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [6:0] cfg_wdata_i,
  prd_stream_if.sink   req_if,
  prd_stream_if.source res_if
);

  localparam int RW    = $clog2(MAX_SAMPLES);
  localparam int CW    = $clog2(MAX_FEATURES + 1);
  localparam int DEPTH = MAX_SAMPLES * MAX_FEATURES;
  localparam int AW    = $clog2(DEPTH);
  localparam int SQW   = 50 + CW;
  localparam int DOTW  = 48 + CW;
  localparam int MANW  = 25 + CW;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MAPA = 9'b000000010,
    S_MAPB = 9'b000000100,
    S_WALK = 9'b000001000,
    S_SQRT = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_DIVI = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [1:0] mode_q;
  logic [6:0] fcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_EUCLID;
      fcount_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIST_MODE:     mode_q   <= cfg_wdata_i[1:0];
        CFG_FEATURE_COUNT: fcount_q <= cfg_wdata_i;
        default:           mode_q   <= mode_q;
      endcase
    end
  end

  // Feature count, limited to the store width.
  logic [CW-1:0] cnt;
  always_comb begin
    if (32'(fcount_q) > MAX_FEATURES) cnt = CW'(MAX_FEATURES);
    else                              cnt = CW'(fcount_q);
  end

  // Request handshake.
  req_item_t req;
  logic      acc;
  assign req           = req_if.data;
  assign req_if.ready  = (state_q == S_IDLE);
  assign acc           = req_if.valid && req_if.ready;

  // Value store: one write port, two read ports with registered data.
  logic [23:0] value_store [DEPTH];
  logic          st_we;
  logic [AW-1:0] st_addr, addr_a, addr_b;
  logic [23:0]   rd_a_q, rd_b_q;
  logic [AW-1:0] base_a_q, base_b_q;
  logic [CW-1:0] k_q;

  assign st_we = acc && (req.req_type == REQ_STORE) &&
                 (32'(req.sample_row) < MAX_SAMPLES) &&
                 (32'(req.feature_slot) < MAX_FEATURES);
  assign st_addr = AW'(req.sample_row) * AW'(MAX_FEATURES) + AW'(req.feature_slot);
  assign addr_a  = base_a_q + AW'(k_q);
  assign addr_b  = base_b_q + AW'(k_q);

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      value_store[st_addr] <= req.sample_value;
    end
    rd_a_q <= value_store[addr_a];
    rd_b_q <= value_store[addr_b];
  end

  // Row map: one write port, one read port with registered data.
  logic [5:0] row_map [MAX_SAMPLES];
  logic          mp_we;
  logic [RW-1:0] map_raddr;
  logic [5:0]    map_rd_q;
  logic [5:0]    pb_q;
  logic          pa_bad_q, pb_bad_q;

  assign mp_we     = acc && (req.req_type == REQ_MAP) && (32'(req.sample_row) < MAX_SAMPLES);
  assign map_raddr = (state_q == S_IDLE) ? RW'(req.pair_first) : RW'(pb_q);

  always_ff @(posedge clk_i) begin
    if (mp_we) begin
      row_map[RW'(req.sample_row)] <= req.map_target;
    end
    map_rd_q <= row_map[map_raddr];
  end

  logic map_ok;
  assign map_ok = (32'(map_rd_q) < MAX_SAMPLES);

  // Walk pipeline: address, read data, products, accumulate.
  logic issue;
  assign issue = (state_q == S_WALK) && (k_q != cnt);

  logic rd_v_q, p_v_q;
  logic za_q, zb_q;

  logic signed [23:0] x, y;
  logic signed [24:0] diff;
  logic [24:0]        md, sq_in;
  logic [23:0]        mx, my;

  assign x     = za_q ? 24'sd0 : $signed(rd_a_q);
  assign y     = zb_q ? 24'sd0 : $signed(rd_b_q);
  assign diff  = 25'(x) - 25'(y);
  assign md    = diff[24] ? 25'(-diff) : 25'(diff);
  assign mx    = x[23] ? 24'(-x) : 24'(x);
  assign my    = y[23] ? 24'(-y) : 24'(y);
  assign sq_in = (mode_q == MODE_EUCLID) ? md : {1'b0, mx};

  logic [49:0]        p_a_q;
  logic [47:0]        p_b_q;
  logic signed [47:0] p_dot_q;
  logic [24:0]        p_man_q;

  logic [SQW-1:0]         acc_a_q, acc_b_q;
  logic signed [DOTW-1:0] acc_dot_q;
  logic [MANW-1:0]        acc_man_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      p_v_q  <= 1'b0;
    end else begin
      rd_v_q <= issue;
      p_v_q  <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_a_q   <= sq_in * sq_in;
    p_b_q   <= my * my;
    p_dot_q <= x * y;
    p_man_q <= md;
  end

  // Bit-serial square root, one result bit from two input bits per cycle.
  logic [63:0] sq_x_q;
  logic [34:0] sq_rem_q, sq_rem_sh, sq_rem_n;
  logic [31:0] sq_root_q, sq_root_n;
  logic [4:0]  sq_i_q;
  logic        sq_sel_q, sq_ge;
  logic [31:0] na_q;

  assign sq_rem_sh = {sq_rem_q[32:0], sq_x_q[63:62]};
  assign sq_ge     = sq_rem_sh >= 35'({sq_root_q, 2'b01});
  assign sq_rem_n  = sq_ge ? sq_rem_sh - 35'({sq_root_q, 2'b01}) : sq_rem_sh;
  assign sq_root_n = {sq_root_q[30:0], sq_ge};

  // Cosine divider: restoring, one quotient bit per cycle.
  logic [63:0] den_q, dv_rem_q, dv_rem_n, dv_a;
  logic [64:0] dv_twice;
  logic [16:0] dv_quo_q, dv_quo_n;
  logic [3:0]  dv_i_q;
  logic        dv_ge;
  logic [DOTW-1:0] dot_mag;

  assign dot_mag  = acc_dot_q[DOTW-1] ? DOTW'(-acc_dot_q) : DOTW'(acc_dot_q);
  assign dv_a     = 64'(dot_mag) << 8;
  assign dv_twice = {dv_rem_q, 1'b0};
  assign dv_ge    = dv_twice >= {1'b0, den_q};
  assign dv_rem_n = dv_ge ? 64'(dv_twice - {1'b0, den_q}) : dv_twice[63:0];
  assign dv_quo_n = {dv_quo_q[15:0], dv_ge};

  logic [63:0] cos_res;
  always_comb begin
    if (acc_dot_q[DOTW-1])             cos_res = ONE_Q16 + 64'(dv_quo_n);
    else if (64'(dv_quo_n) >= ONE_Q16) cos_res = '0;
    else                               cos_res = ONE_Q16 - 64'(dv_quo_n);
  end

  // Output register.
  logic        res_valid_q, res_ld;
  res_item_t   res_data_q;
  logic [63:0] res_q;

  assign res_ld = (state_q == S_DONE) && (!res_valid_q || res_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ld) begin
      res_valid_q <= 1'b1;
    end else if (res_if.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ld) begin
      if (res_q[63:48] != '0) begin
        res_data_q.distance  <= '1;
        res_data_q.saturated <= 1'b1;
      end else begin
        res_data_q.distance  <= res_q[47:0];
        res_data_q.saturated <= 1'b0;
      end
    end
  end

  assign res_if.valid = res_valid_q;
  assign res_if.data  = res_data_q;

  // Sequencer.
  logic walk_done, sq_last;
  assign walk_done = (k_q == cnt) && !rd_v_q && !p_v_q;
  assign sq_last   = (sq_i_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (acc && (req.req_type == REQ_QUERY)) state_d = S_MAPA;
      S_MAPA: state_d = S_MAPB;
      S_MAPB: state_d = S_WALK;
      S_WALK: begin
        if (walk_done) begin
          unique case (mode_q)
            MODE_EUCLID, MODE_COSINE: state_d = S_SQRT;
            default:                  state_d = S_DONE;
          endcase
        end
      end
      S_SQRT: begin
        if (sq_last) begin
          if (mode_q == MODE_EUCLID)              state_d = S_DONE;
          else if (!sq_sel_q)                     state_d = S_SQRT;
          else if (na_q == '0 || sq_root_n == '0) state_d = S_DONE;
          else                                    state_d = S_MUL;
        end
      end
      S_MUL:  state_d = S_DIVI;
      S_DIVI: state_d = S_DIV;
      S_DIV:  if (dv_i_q == '0) state_d = S_DONE;
      S_DONE: if (res_ld) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Query datapath.
  always_ff @(posedge clk_i) begin
    if (p_v_q) begin
      acc_a_q   <= acc_a_q + SQW'(p_a_q);
      acc_b_q   <= acc_b_q + SQW'(p_b_q);
      acc_dot_q <= acc_dot_q + DOTW'(p_dot_q);
      acc_man_q <= acc_man_q + MANW'(p_man_q);
    end
    if (issue) begin
      k_q <= k_q + 1'b1;
    end
    unique case (state_q)
      S_IDLE: begin
        pb_q     <= req.pair_second;
        pa_bad_q <= !(32'(req.pair_first) < MAX_SAMPLES);
        pb_bad_q <= !(32'(req.pair_second) < MAX_SAMPLES);
      end
      S_MAPA: begin
        za_q     <= pa_bad_q || !map_ok;
        base_a_q <= map_ok ? AW'(map_rd_q) * AW'(MAX_FEATURES) : '0;
      end
      S_MAPB: begin
        zb_q      <= pb_bad_q || !map_ok;
        base_b_q  <= map_ok ? AW'(map_rd_q) * AW'(MAX_FEATURES) : '0;
        k_q       <= '0;
        acc_a_q   <= '0;
        acc_b_q   <= '0;
        acc_dot_q <= '0;
        acc_man_q <= '0;
      end
      S_WALK: begin
        if (walk_done) begin
          sq_x_q    <= 64'(acc_a_q) << 8;
          sq_rem_q  <= '0;
          sq_root_q <= '0;
          sq_i_q    <= 5'd31;
          sq_sel_q  <= 1'b0;
          res_q     <= (mode_q == MODE_MANHATTAN) ? (64'(acc_man_q) << 4) : '0;
        end
      end
      S_SQRT: begin
        if (sq_last && (mode_q != MODE_EUCLID) && !sq_sel_q) begin
          // First norm done; start the second one.
          na_q      <= sq_root_n;
          sq_x_q    <= 64'(acc_b_q) << 8;
          sq_rem_q  <= '0;
          sq_root_q <= '0;
          sq_i_q    <= 5'd31;
          sq_sel_q  <= 1'b1;
        end else begin
          sq_x_q    <= {sq_x_q[61:0], 2'b00};
          sq_rem_q  <= sq_rem_n;
          sq_root_q <= sq_root_n;
          sq_i_q    <= sq_i_q - 1'b1;
          if (sq_last) begin
            if (mode_q == MODE_EUCLID) begin
              res_q <= 64'(sq_root_n);
            end else begin
              // A zero norm makes the distance exactly one.
              res_q <= ONE_Q16;
              den_q <= 64'(sq_root_n);
            end
          end
        end
      end
      S_MUL: begin
        den_q <= 64'(na_q) * den_q[31:0];
      end
      S_DIVI: begin
        // The ratio is below two, so the integer part is a single compare.
        dv_rem_q <= (dv_a >= den_q) ? dv_a - den_q : dv_a;
        dv_quo_q <= {16'd0, dv_a >= den_q};
        dv_i_q   <= 4'd15;
      end
      S_DIV: begin
        dv_rem_q <= dv_rem_n;
        dv_quo_q <= dv_quo_n;
        dv_i_q   <= dv_i_q - 1'b1;
        if (dv_i_q == '0) begin
          res_q <= cos_res;
        end
      end
      S_DONE: begin
        res_q <= res_q;
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  `PRD_ASSERT_NEXT(a_query_starts, acc && (req.req_type == REQ_QUERY), state_q == S_MAPA)
  `PRD_ASSERT(a_walk_drained, (state_q == S_WALK) && (state_d != S_WALK), !rd_v_q && !p_v_q)
  `PRD_ASSERT(a_div_nonzero, state_q == S_DIV, den_q != '0)
  `PRD_ASSERT(a_busy_no_accept, state_q != S_IDLE, !req_if.ready)

endmodule
